// ===== design/sm3_pkg.sv =====
package sm3_pkg;

  // Round constants and initial chain value
  localparam logic [31:0] SM3_T_LOW  = 32'h79cc4519;
  localparam logic [31:0] SM3_T_HIGH = 32'h7a879d8a;
  localparam logic [7:0][31:0] SM3_IV = {
    32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
    32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f
  };

  localparam logic [31:0] SM3_PAD_MARK = 32'h80000000;

  typedef logic [7:0][31:0] sm3_state_t;

  // Input and output items
  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        last;
  } sm3_in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        digest_last;
  } sm3_out_item_t;

  // Controls from the sequencer to the round unit
  typedef struct packed {
    logic init;
    logic step;
    logic fold;
    logic iv_load;
  } sm3_ctrl_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] dbl;
    dbl = {x, x} << n;
    return dbl[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
  endfunction

  // Round constant rotated by the round number
  function automatic logic [31:0] t_rot(input logic [5:0] j);
    logic [31:0] t;
    t = (j[5:4] == 2'b00) ? SM3_T_LOW : SM3_T_HIGH;
    return rotl32(t, j[4:0]);
  endfunction

endpackage

// ===== design/sm3_hash_engine.sv =====
// Each non-final word is taken while the engine is idle; every 16th word starts a block
// that occupies the round unit for 64 rounds (one round per cycle) plus a
// fold step. After the final word the padding words are pushed, adding
// one or two more blocks, then 8 digest items follow.
// Reset loads the chain value with the IV and clears the length and counters.
module sm3_hash_engine (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  sm3_pkg::sm3_in_item_t  in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output sm3_pkg::sm3_out_item_t out_item_o
);
  import sm3_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_e;

  state_e      state_q, state_d;
  logic [3:0]  pos_q, pos_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [63:0] len_q, len_d;
  logic        pad_q, pad_d;
  logic        mark_q, mark_d;
  logic        hi_q, hi_d;
  logic        dig_q, dig_d;

  sm3_ctrl_t   ctrl;
  sm3_state_t  chain;
  logic [31:0] w_j, wp_j;
  logic        push;
  logic [31:0] push_word;
  logic [2:0]  vb_c;
  logic [4:0]  sh;
  logic [31:0] last_word;
  logic        in_acc, out_acc;

  // Clamp byte count and build the padded final word
  assign vb_c      = (in_item_i.valid_bytes > 3'd4) ? 3'd4 : in_item_i.valid_bytes;
  assign sh        = {vb_c[1:0], 3'b000};
  assign last_word = (in_item_i.data_word & ~(32'hffffffff >> sh)) | (SM3_PAD_MARK >> sh);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_OUT);
  assign out_acc     = out_valid_o && out_ready_i;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    rnd_d     = rnd_q;
    cnt_d     = cnt_q;
    len_d     = len_q;
    pad_d     = pad_q;
    mark_d    = mark_q;
    hi_d      = hi_q;
    dig_d     = dig_q;
    ctrl      = '0;
    push      = 1'b0;
    push_word = in_item_i.data_word;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          push = 1'b1;
          if (in_item_i.last) begin
            if (vb_c != 3'd4) begin
              push_word = last_word;
            end
            len_d   = len_q + {58'd0, vb_c, 3'b000};
            pad_d   = 1'b1;
            mark_d  = (vb_c == 3'd4);
            hi_d    = 1'b0;
            state_d = ST_PAD;
          end else begin
            len_d = len_q + 64'd32;
          end
        end
      end
      ST_PAD: begin
        push = 1'b1;
        if (mark_q) begin
          push_word = SM3_PAD_MARK;
          mark_d    = 1'b0;
        end else if (hi_q) begin
          push_word = len_q[31:0];
          hi_d      = 1'b0;
          pad_d     = 1'b0;
          dig_d     = 1'b1;
        end else if (pos_q == 4'd14) begin
          push_word = len_q[63:32];
          hi_d      = 1'b1;
        end else begin
          push_word = '0;
        end
      end
      ST_ROUND: begin
        ctrl.step = 1'b1;
        rnd_d     = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        ctrl.fold = 1'b1;
        if (pad_q) begin
          state_d = ST_PAD;
        end else if (dig_q) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          cnt_d = cnt_q + 3'd1;
          if (cnt_q == 3'd7) begin
            ctrl.iv_load = 1'b1;
            dig_d        = 1'b0;
            len_d        = '0;
            state_d      = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Advance the block fill; a full block starts the rounds
    if (push) begin
      pos_d = pos_q + 4'd1;
      if (pos_q == 4'd15) begin
        ctrl.init = 1'b1;
        rnd_d     = '0;
        state_d   = ST_ROUND;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      rnd_q   <= '0;
      cnt_q   <= '0;
      len_q   <= '0;
      pad_q   <= 1'b0;
      mark_q  <= 1'b0;
      hi_q    <= 1'b0;
      dig_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      rnd_q   <= rnd_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      pad_q   <= pad_d;
      mark_q  <= mark_d;
      hi_q    <= hi_d;
      dig_q   <= dig_d;
    end
  end

  sm3_msg_sched u_sched (
    .clk_i       (clk_i),
    .load_i      (push),
    .load_word_i (push_word),
    .step_i      (ctrl.step),
    .w_o         (w_j),
    .wp_o        (wp_j)
  );

  sm3_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .round_i (rnd_q),
    .w_i     (w_j),
    .wp_i    (wp_j),
    .chain_o (chain)
  );

  // Present digest words A through H
  assign out_item_o.digest_word = chain[cnt_q];
  assign out_item_o.digest_last = (cnt_q == 3'd7);

endmodule

// ===== design/sm3_msg_sched.sv =====
module sm3_msg_sched (
  input  logic        clk_i,
  input  logic        load_i,
  input  logic [31:0] load_word_i,
  input  logic        step_i,
  output logic [31:0] w_o,
  output logic [31:0] wp_o
);
  import sm3_pkg::*;

  // win_q[0] holds W[j], win_q[15] holds W[j+15]
  logic [15:0][31:0] win_q, win_d;
  logic [31:0]       exp_word;

  // Next expanded word W[j+16]
  assign exp_word = perm1(win_q[0] ^ win_q[7] ^ rotl32(win_q[13], 5'd15))
                  ^ rotl32(win_q[3], 5'd7) ^ win_q[10];

  // Shift in either a message word or an expanded word
  always_comb begin
    win_d = win_q;
    if (load_i || step_i) begin
      for (int k = 0; k < 15; k++) begin
        win_d[k] = win_q[k+1];
      end
      win_d[15] = load_i ? load_word_i : exp_word;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  assign w_o  = win_q[0];
  assign wp_o = win_q[0] ^ win_q[4];

endmodule

// ===== design/sm3_round.sv =====
module sm3_round (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sm3_pkg::sm3_ctrl_t  ctrl_i,
  input  logic [5:0]          round_i,
  input  logic [31:0]         w_i,
  input  logic [31:0]         wp_i,
  output sm3_pkg::sm3_state_t chain_o
);
  import sm3_pkg::*;

  sm3_state_t  chain_q, chain_d;
  sm3_state_t  work_q, work_d;
  sm3_state_t  work_nx;
  logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2;
  logic        low_rnd;

  // One compression round
  always_comb begin
    low_rnd = (round_i[5:4] == 2'b00);
    a12 = rotl32(work_q[0], 5'd12);
    ss1 = rotl32(a12 + work_q[4] + t_rot(round_i), 5'd7);
    ss2 = ss1 ^ a12;
    ff  = low_rnd ? (work_q[0] ^ work_q[1] ^ work_q[2])
                  : ((work_q[0] & work_q[1]) | (work_q[0] & work_q[2])
                    | (work_q[1] & work_q[2]));
    gg  = low_rnd ? (work_q[4] ^ work_q[5] ^ work_q[6])
                  : ((work_q[4] & work_q[5]) | (~work_q[4] & work_q[6]));
    tt1 = ff + work_q[3] + ss2 + wp_i;
    tt2 = gg + work_q[7] + ss1 + w_i;
    work_nx[0] = tt1;
    work_nx[1] = work_q[0];
    work_nx[2] = rotl32(work_q[1], 5'd9);
    work_nx[3] = work_q[2];
    work_nx[4] = perm0(tt2);
    work_nx[5] = work_q[4];
    work_nx[6] = rotl32(work_q[5], 5'd19);
    work_nx[7] = work_q[6];
  end

  // Select next work and chain values
  always_comb begin
    work_d  = work_q;
    chain_d = chain_q;
    if (ctrl_i.init) begin
      work_d = chain_q;
    end else if (ctrl_i.step) begin
      work_d = work_nx;
    end
    if (ctrl_i.iv_load) begin
      chain_d = SM3_IV;
    end else if (ctrl_i.fold) begin
      chain_d = chain_q ^ work_q;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= SM3_IV;
    end else begin
      chain_q <= chain_d;
    end
  end

  assign chain_o = chain_q;

endmodule
